// File: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Operation codes, status codes and the access request that the pointer
// unit hands to the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 7;

  typedef enum logic [KindW-1:0] {
    KIND_ADD_BACK     = 2'd0,
    KIND_REMOVE_BACK  = 2'd1,
    KIND_ADD_FRONT    = 2'd2,
    KIND_REMOVE_FRONT = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // At most one memory access per transaction: a write for an add, a read for a remove; none for a rejected one.
  typedef struct packed {
    logic    we;
    logic    re;
    status_e status;
  } access_t;

endpackage

// File: src/deq_if.sv
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if: request and result channels
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic                           valid;
  logic                           ready;
  logic [deq_pkg::KindW-1:0]      kind;
  logic [deq_pkg::ValueW-1:0]     value_in;

  modport source (output valid, kind, value_in, input ready);
  modport sink   (input valid, kind, value_in, output ready);
endinterface

interface deq_out_if;
  logic                           valid;
  logic                           ready;
  logic [deq_pkg::ValueW-1:0]     value_out;
  logic [deq_pkg::StatusW-1:0]    status;
  logic [deq_pkg::LenW-1:0]       length_after;

  modport source (output valid, value_out, status, length_after, input ready);
  modport sink   (input valid, value_out, status, length_after, output ready);
endinterface

// File: src/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: generic single-port RAM
// One write or one read per cycle; read data registered, held between reads.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/deq_ptr.sv
// ----------------------------------------------------------------------------
// deq_ptr: front/back pointers and fill count
// Decodes the operation, picks the memory address and updates the pointers
// and the count on each accepted transaction.
// ----------------------------------------------------------------------------
module deq_ptr #(
  parameter int unsigned Depth = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic [deq_pkg::KindW-1:0]     kind_i,
  output logic [$clog2(Depth)-1:0]      addr_o,
  output deq_pkg::access_t              access_o,
  output logic [$clog2(Depth+1)-1:0]    count_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt = CntW'(Depth);

  logic [AddrW-1:0] front_q, front_d;
  logic [AddrW-1:0] back_q, back_d;
  logic [CntW-1:0]  count_q, count_d;

  logic [AddrW-1:0] front_next, front_prev, back_next, back_prev;
  logic             full, empty;

  assign front_next = (front_q == LastIdx) ? '0 : front_q + AddrW'(1);
  assign front_prev = (front_q == '0) ? LastIdx : front_q - AddrW'(1);
  assign back_next  = (back_q == LastIdx) ? '0 : back_q + AddrW'(1);
  assign back_prev  = (back_q == '0) ? LastIdx : back_q - AddrW'(1);
  assign full       = (count_q == FullCnt);
  assign empty      = (count_q == '0);

  always_comb begin
    front_d         = front_q;
    back_d          = back_q;
    count_d         = count_q;
    addr_o          = back_q;
    access_o.we     = 1'b0;
    access_o.re     = 1'b0;
    access_o.status = deq_pkg::STATUS_OK;
    unique case (deq_pkg::kind_e'(kind_i))
      deq_pkg::KIND_ADD_BACK: begin
        addr_o = back_q;
        if (full) begin
          access_o.status = deq_pkg::STATUS_FULL;
        end else begin
          access_o.we = take_i;
          back_d      = back_next;
          count_d     = count_q + CntW'(1);
        end
      end
      deq_pkg::KIND_REMOVE_BACK: begin
        addr_o = back_prev;
        if (empty) begin
          access_o.status = deq_pkg::STATUS_EMPTY;
        end else begin
          access_o.re = take_i;
          back_d      = back_prev;
          count_d     = count_q - CntW'(1);
        end
      end
      deq_pkg::KIND_ADD_FRONT: begin
        addr_o = front_prev;
        if (full) begin
          access_o.status = deq_pkg::STATUS_FULL;
        end else begin
          access_o.we = take_i;
          front_d     = front_prev;
          count_d     = count_q + CntW'(1);
        end
      end
      deq_pkg::KIND_REMOVE_FRONT: begin
        addr_o = front_q;
        if (empty) begin
          access_o.status = deq_pkg::STATUS_EMPTY;
        end else begin
          access_o.re = take_i;
          front_d     = front_next;
          count_d     = count_q - CntW'(1);
        end
      end
      default: begin
        addr_o = back_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else if (take_i) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_d;

endmodule

// File: src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: deque of data words in a ring buffer
// Pipeline: an accepted request passes the RAM stage (s1) and the output register,
// where its result is valid at the output and held until the consumer takes it.
// Throughput: one transaction per cycle unless the output stalls; each touches
// one single-port RAM entry, and pointers update at accept so the next can follow.
// Reset: pointers and count clear at once (queue empty); RAM contents stay
// undefined, never read before written. No clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_in_if.sink     in_i,
  deq_out_if.source  out_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  logic                  take;
  logic [AddrW-1:0]      addr;
  deq_pkg::access_t      access;
  logic [CntW-1:0]       count_next;
  logic [63:0]           wdata_ext;
  logic [DATA_WIDTH-1:0] rdata;
  logic [63:0]           rdata_ext;

  // RAM stage: request taken, read data on its way
  logic                         s1_valid_q;
  logic                         s1_rd_q;
  deq_pkg::status_e             s1_status_q;
  logic [deq_pkg::LenW-1:0]     s1_len_q;
  logic                         s1_adv;

  // Output register
  logic                         out_valid_q;
  logic [deq_pkg::ValueW-1:0]   out_value_q;
  deq_pkg::status_e             out_status_q;
  logic [deq_pkg::LenW-1:0]     out_len_q;
  logic                         out_free;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign take       = in_i.valid && in_i.ready;

  deq_ptr #(
    .Depth (DEPTH)
  ) u_ptr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .kind_i   (in_i.kind),
    .addr_o   (addr),
    .access_o (access),
    .count_o  (count_next)
  );

  assign wdata_ext = {32'b0, in_i.value_in};

  deq_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (access.we),
    .re_i    (access.re),
    .addr_i  (addr),
    .wdata_i (wdata_ext[DATA_WIDTH-1:0]),
    .rdata_o (rdata)
  );

  assign rdata_ext = 64'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= take;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_rd_q     <= access.re;
      s1_status_q <= access.status;
      s1_len_q    <= deq_pkg::LenW'(count_next);
    end
    // RAM read data holds while s1 stalls: no new read is issued then
    if (s1_adv) begin
      out_value_q  <= s1_rd_q ? rdata_ext[deq_pkg::ValueW-1:0] : '0;
      out_status_q <= s1_status_q;
      out_len_q    <= s1_len_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.value_out    = out_value_q;
  assign out_o.status       = out_status_q;
  assign out_o.length_after = out_len_q;

endmodule

// File: src/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker: port-level checks of the double-ended queue
// Watches the result channel and checks status, value and length against
// each other.
// ----------------------------------------------------------------------------
module deq_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [deq_pkg::ValueW-1:0]    value_out_i,
  input logic [deq_pkg::StatusW-1:0]   status_i,
  input logic [deq_pkg::LenW-1:0]      length_after_i
);

  localparam logic [deq_pkg::LenW-1:0] FullLen = deq_pkg::LenW'(DEPTH);

  // Hold the result while the consumer stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(value_out_i) && $stable(status_i) && $stable(length_after_i))
    else $error("result changed under stall");

  // A rejected operation returns no word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != deq_pkg::STATUS_OK) |-> value_out_i == '0)
    else $error("rejected operation returned data");

  // Empty status only with an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == deq_pkg::STATUS_EMPTY) |-> length_after_i == '0)
    else $error("empty status with nonzero length");

  // Full status only with a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == deq_pkg::STATUS_FULL) |-> length_after_i == FullLen)
    else $error("full status with queue not full");

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .value_out_i    (out_o.value_out),
  .status_i       (out_o.status),
  .length_after_i (out_o.length_after)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the double-ended queue
// Pushes directed and random add/remove requests at both ends of the queue
// and checks every result word, status and fill level against a ring-buffer
// predictor kept in step with the accepted requests.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH    = 64;
  localparam int unsigned QWIDTH    = 32;
  localparam int unsigned PrintCap  = 40;

  typedef struct {
    deq_pkg::kind_e             kind;
    logic [deq_pkg::ValueW-1:0] word;
  } deq_op_t;

  typedef struct {
    logic [deq_pkg::ValueW-1:0] word;
    deq_pkg::status_e           status;
    logic [deq_pkg::LenW-1:0]   fill_after;
  } deq_result_t;

  logic clk_i;
  logic rst_ni;

  deq_in_if  req_if ();
  deq_out_if res_if ();

  double_ended_queue #(
    .DEPTH      (QDEPTH),
    .DATA_WIDTH (QWIDTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // Predicted queue contents
  logic [QWIDTH-1:0]        ring_mem [QDEPTH];
  logic [5:0]               ring_front;
  logic [5:0]               ring_back;
  logic [deq_pkg::LenW-1:0] ring_fill;

  deq_op_t     pending_ops [$];
  deq_result_t expected_results [$];
  deq_op_t     next_op;
  deq_result_t got_result;
  deq_result_t want_result;

  logic req_taken;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   ops_queued;
  int   ops_accepted;
  int   results_checked;
  int   empty_rejects;
  int   full_rejects;
  int   words_removed;
  int   error_count;

  function automatic deq_result_t apply_op(deq_pkg::kind_e op,
                                           logic [deq_pkg::ValueW-1:0] word);
    deq_result_t r;
    r.word   = '0;
    r.status = deq_pkg::STATUS_OK;
    case (op)
      deq_pkg::KIND_ADD_BACK: begin
        if (ring_fill == QDEPTH) begin
          r.status = deq_pkg::STATUS_FULL;
        end else begin
          ring_mem[ring_back] = word[QWIDTH-1:0];
          ring_back = ring_back + 6'd1;
          ring_fill = ring_fill + 1'b1;
        end
      end
      deq_pkg::KIND_ADD_FRONT: begin
        if (ring_fill == QDEPTH) begin
          r.status = deq_pkg::STATUS_FULL;
        end else begin
          ring_front = ring_front - 6'd1;
          ring_mem[ring_front] = word[QWIDTH-1:0];
          ring_fill = ring_fill + 1'b1;
        end
      end
      deq_pkg::KIND_REMOVE_BACK: begin
        if (ring_fill == 0) begin
          r.status = deq_pkg::STATUS_EMPTY;
        end else begin
          ring_back = ring_back - 6'd1;
          r.word = ring_mem[ring_back];
          ring_fill = ring_fill - 1'b1;
        end
      end
      default: begin
        if (ring_fill == 0) begin
          r.status = deq_pkg::STATUS_EMPTY;
        end else begin
          r.word = ring_mem[ring_front];
          ring_front = ring_front + 6'd1;
          ring_fill = ring_fill - 1'b1;
        end
      end
    endcase
    r.fill_after = ring_fill;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < PrintCap) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic queue_op(deq_pkg::kind_e op, logic [deq_pkg::ValueW-1:0] word);
    deq_op_t item;
    item.kind = op;
    item.word = word;
    pending_ops.push_back(item);
    ops_queued++;
  endtask

  function automatic logic [deq_pkg::ValueW-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random walk: add_pct biases toward filling or draining the queue
  task automatic queue_burst(int n, int add_pct);
    logic front_side;
    for (int i = 0; i < n; i++) begin
      front_side = 1'($urandom_range(1));
      if ($urandom_range(99) < add_pct) begin
        queue_op(front_side ? deq_pkg::KIND_ADD_FRONT : deq_pkg::KIND_ADD_BACK,
                 pick_word());
      end else begin
        queue_op(front_side ? deq_pkg::KIND_REMOVE_FRONT : deq_pkg::KIND_REMOVE_BACK,
                 pick_word());
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (ops_accepted != ops_queued || expected_results.size() != 0);
  endtask

  task automatic run_phase(int send_pct, int stall_pct, int n_items);
    int left;
    int n;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    left = n_items;
    while (left > 0) begin
      n = $urandom_range(150, 20);
      if (n > left) n = left;
      case ($urandom_range(2))
        0:       queue_burst(n, 85);
        1:       queue_burst(n, 15);
        default: queue_burst(n, 50);
      endcase
      left -= n;
    end
    wait_drained();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  // Driver: hold a request until it is taken, then advance
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_op = pending_ops.pop_front();
        req_if.valid    <= 1'b1;
        req_if.kind     <= next_op.kind;
        req_if.value_in <= next_op.word;
      end else begin
        req_if.valid    <= 1'b0;
        req_if.kind     <= deq_pkg::KindW'($urandom);
        req_if.value_in <= $urandom;
      end
    end
    res_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on request transactions, check on result transactions
  always @(posedge clk_i) begin
    req_taken <= req_if.valid && req_if.ready;
    if (rst_ni && req_if.valid && req_if.ready) begin
      want_result = apply_op(deq_pkg::kind_e'(req_if.kind), req_if.value_in);
      expected_results.push_back(want_result);
      ops_accepted++;
      case (want_result.status)
        deq_pkg::STATUS_EMPTY: empty_rejects++;
        deq_pkg::STATUS_FULL:  full_rejects++;
        default:               ;
      endcase
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_result.word       = res_if.value_out;
      got_result.status     = deq_pkg::status_e'(res_if.status);
      got_result.fill_after = res_if.length_after;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending: word %h status %0d len %0d",
                                  got_result.word, got_result.status,
                                  got_result.fill_after));
      end else begin
        want_result = expected_results.pop_front();
        results_checked++;
        if (got_result.word !== want_result.word) begin
          report_mismatch($sformatf("value_out %h, want %h",
                                    got_result.word, want_result.word));
        end
        if (got_result.status !== want_result.status) begin
          report_mismatch($sformatf("status %0d, want %0d",
                                    res_if.status, want_result.status));
        end
        if (got_result.fill_after !== want_result.fill_after) begin
          report_mismatch($sformatf("length_after %0d, want %0d",
                                    got_result.fill_after, want_result.fill_after));
        end
        if (want_result.status == deq_pkg::STATUS_OK &&
            (want_result.fill_after < ring_fill || got_result.word !== '0)) begin
          words_removed += (want_result.word !== '0 || got_result.word !== '0) ? 1 : 0;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = deq_pkg::KIND_ADD_BACK;
    req_if.value_in = '0;
    res_if.ready    = 1'b0;
    req_taken       = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    ops_queued      = 0;
    ops_accepted    = 0;
    results_checked = 0;
    empty_rejects   = 0;
    full_rejects    = 0;
    words_removed   = 0;
    error_count     = 0;
    ring_front      = '0;
    ring_back       = '0;
    ring_fill       = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: removals when empty, extreme words at both ends, wrap below zero
    queue_op(deq_pkg::KIND_REMOVE_BACK, 32'hFFFF_FFFF);
    queue_op(deq_pkg::KIND_REMOVE_FRONT, 32'h0000_0000);
    queue_op(deq_pkg::KIND_ADD_BACK, 32'h0000_0000);
    queue_op(deq_pkg::KIND_ADD_BACK, 32'hFFFF_FFFF);
    queue_op(deq_pkg::KIND_ADD_FRONT, 32'hAAAA_AAAA);
    queue_op(deq_pkg::KIND_ADD_FRONT, 32'h5555_5555);
    queue_op(deq_pkg::KIND_REMOVE_FRONT, 32'hFFFF_FFFF);
    queue_op(deq_pkg::KIND_REMOVE_BACK, 32'h0000_0000);
    queue_op(deq_pkg::KIND_REMOVE_FRONT, 32'h1234_5678);
    queue_op(deq_pkg::KIND_REMOVE_BACK, 32'h8765_4321);
    queue_op(deq_pkg::KIND_REMOVE_FRONT, 32'h0000_0001);
    queue_op(deq_pkg::KIND_ADD_FRONT, 32'h8000_0000);
    queue_op(deq_pkg::KIND_REMOVE_BACK, 32'h0000_0000);
    queue_op(deq_pkg::KIND_ADD_BACK, 32'h0000_0001);
    queue_op(deq_pkg::KIND_REMOVE_FRONT, 32'h0000_0000);
    queue_op(deq_pkg::KIND_REMOVE_BACK, 32'h7FFF_FFFF);

    // Fill past full and drain past empty with random words and ends
    queue_burst(68, 100);
    queue_burst(68, 0);
    run_phase(0, 0, 280);
    run_phase(54, 0, 420);
    run_phase(0, 54, 420);
    run_phase(10, 10, 420);

    repeat (6) @(posedge clk_i);
    $display("ran %0d queue operations, %0d results checked", ops_accepted, results_checked);
    $display("rejected %0d removals on empty and %0d adds on full", empty_rejects,
             full_rejects);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/deq_pkg.sv
src/deq_if.sv
src/deq_ram.sv
src/deq_ptr.sv
src/double_ended_queue.sv
src/deq_checker.sv
tb/testbench.sv
